@@ hw/rtl/pds_pkg.sv @@
// shared types, constants and codes for the polyline dash splitter
package pds_pkg;

  // fixed field widths
  localparam int COORD_W = 24;
  localparam int LEN_W   = 25;
  localparam int SQ_W    = 50;
  localparam int SLOT_W  = 16;
  localparam int CNT_W   = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // parameter defaults
  localparam int PATTERN_SLOTS_DEF        = 4;
  localparam int MAX_DASHES_PER_POINT_DEF = 64;
  localparam int VERTEX_LIMIT_DEF         = 1 << 21;
  localparam int VERTS_PER_DASH           = 2;

  // register reset values
  localparam logic [SLOT_W-1:0] SLOT_RST = 16'd256;

  // register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_COUNT = 3'd0,
    REG_SLOT_LEN_0    = 3'd1,
    REG_SLOT_LEN_1    = 3'd2,
    REG_SLOT_LEN_2    = 3'd3,
    REG_SLOT_LEN_3    = 3'd4,
    REG_LINE_WIDTH    = 3'd5
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT_MUL,
    S_SLOT_LOAD,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_SUM,
    S_ROOT,
    S_ROOT_WAIT,
    S_WALK,
    S_IP_MUL,
    S_IP_DIV,
    S_IP_WAIT,
    S_PUSH,
    S_ADVANCE,
    S_FINISH
  } state_t;

  // operations of the root / divide unit
  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

endpackage

@@ hw/rtl/pds_in_if.sv @@
// vertex input channel
interface pds_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pds_pkg::COORD_W-1:0] px;
  logic signed [pds_pkg::COORD_W-1:0] py;
  logic                              first;

  modport source (output valid, output px, output py, output first, input ready);
  modport sink   (input valid, input px, input py, input first, output ready);
endinterface

@@ hw/rtl/pds_out_if.sv @@
// dash piece output channel
interface pds_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pds_pkg::COORD_W-1:0] start_x;
  logic signed [pds_pkg::COORD_W-1:0] start_y;
  logic signed [pds_pkg::COORD_W-1:0] end_x;
  logic signed [pds_pkg::COORD_W-1:0] end_y;
  logic                              last;
  logic                              dropped;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, output last, output dropped, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, input last, input dropped, output ready);
endinterface

@@ hw/rtl/pds_rootdiv.sv @@
// iterative unit: integer square root and long division on one shared subtractor
module pds_rootdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pds_pkg::unit_req_t             req,
  input  logic [pds_pkg::SQ_W-1:0]       operand,
  input  logic [pds_pkg::LEN_W-1:0]      divisor,
  output logic                           done,
  output logic [pds_pkg::LEN_W-1:0]      result
);
  localparam int L  = pds_pkg::LEN_W;
  localparam int SW = pds_pkg::SQ_W;
  localparam int DW = SW + 2;

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic              done_r;
  pds_pkg::unit_op_t op_r;
  // root state
  logic [SW-1:0]     v_r;
  logic [SW:0]       root_r;
  logic [SW-1:0]     bit_r;
  // divide state
  logic [L-1:0]      rem_r;
  logic [L-1:0]      low_r;
  logic [L-1:0]      quo_r;

  logic [DW-1:0]     sub_a;
  logic [DW-1:0]     sub_b;
  logic [DW-1:0]     diff;
  logic              ge;

  // shared compare and subtract
  always_comb begin
    if (op_r == pds_pkg::OP_SQRT) begin
      sub_a = {2'b00, v_r};
      sub_b = {1'b0, root_r} + {2'b00, bit_r};
    end else begin
      sub_a = {{(DW-L-1){1'b0}}, rem_r, low_r[L-1]};
      sub_b = {{(DW-L){1'b0}}, divisor};
    end
    diff = sub_a - sub_b;
    ge   = ~diff[DW-1];
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= pds_pkg::OP_SQRT;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(L - 1);
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      v_r    <= operand;
      root_r <= '0;
      bit_r  <= SW'(1) << (SW - 2);
      rem_r  <= operand[SW-1:L];
      low_r  <= operand[L-1:0];
      quo_r  <= '0;
    end else if (busy_r) begin
      if (op_r == pds_pkg::OP_SQRT) begin
        if (ge) begin
          v_r    <= diff[SW-1:0];
          root_r <= (root_r >> 1) + {1'b0, bit_r};
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        rem_r <= ge ? diff[L-1:0] : {rem_r[L-2:0], low_r[L-1]};
        low_r <= {low_r[L-2:0], 1'b0};
        quo_r <= {quo_r[L-2:0], ge};
      end
    end
  end

  assign done   = done_r;
  assign result = (op_r == pds_pkg::OP_SQRT) ? root_r[L-1:0] : quo_r;

endmodule

@@ hw/rtl/polyline_dash_splitter.sv @@
// polyline dash splitter top level: sequencer, registers and output stage
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    px, py, first
//  out_ch   out  valid/ready    start_x, start_y, end_x, end_y, last, dropped
//  apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// a first vertex runs the slot length multiply; a segment runs the squares
// and the 25-step root, then per dash 4 interpolations (multiply plus 25-step
// division on the shared unit) and a slot length reload per slot change.
// in_ch.ready is high only in idle.
// reset is synchronous active low; a stalled output holds the sequencer
// once a second dash waits behind the output register.
module polyline_dash_splitter #(
  parameter int PATTERN_SLOTS        = pds_pkg::PATTERN_SLOTS_DEF,
  parameter int MAX_DASHES_PER_POINT = pds_pkg::MAX_DASHES_PER_POINT_DEF,
  parameter int VERTEX_LIMIT         = pds_pkg::VERTEX_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pds_in_if.sink                         in_ch,
  pds_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pds_pkg::ADDR_W-1:0]     paddr,
  input  logic [pds_pkg::DATA_W-1:0]     pwdata,
  output logic [pds_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  localparam int CW   = pds_pkg::COORD_W;
  localparam int L    = pds_pkg::LEN_W;
  localparam int SW   = pds_pkg::SQ_W;
  localparam int VT_W = $clog2(VERTEX_LIMIT + 1);
  localparam int DN_W = $clog2(MAX_DASHES_PER_POINT + 1);
  localparam logic [2:0] SLOT_CAP = 3'((PATTERN_SLOTS < 4) ? PATTERN_SLOTS : 4);

  // configuration registers
  logic [2:0]                  pat_cnt_r;
  logic [pds_pkg::SLOT_W-1:0]  slot_len_r [4];
  logic [pds_pkg::SLOT_W-1:0]  line_w_r;

  pds_pkg::state_t state_r, state_nxt;

  logic signed [CW-1:0] prev_x_r, prev_y_r, x0_r, y0_r;
  logic                 have_prev_r, halted_r, in_walk_r;
  logic [1:0]           slot_r, ip_idx_r;
  logic [L-1:0]         rem_r, len_r, trav_r, segrem_r, dxm_r, dym_r;
  logic                 dxn_r, dyn_r;
  logic [VT_W-1:0]      vt_r;
  logic [DN_W-1:0]      dash_n_r;
  logic                 dropped_r;
  logic [SW-1:0]        sum_r, mul_p_r;
  logic [CW-1:0]        dash_r [4];
  logic [CW-1:0]        pend_r [4];
  logic                 pend_valid_r;
  logic [CW-1:0]        out_pt_r [4];
  logic                 out_valid_r, out_last_r, out_drop_r;

  // configuration port
  logic       wr_en;
  logic [2:0] reg_idx;
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[pds_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r <= '0;
      for (int i = 0; i < 4; i++) slot_len_r[i] <= pds_pkg::SLOT_RST;
      line_w_r  <= pds_pkg::SLOT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pds_pkg::REG_PATTERN_COUNT: pat_cnt_r     <= pwdata[2:0];
        pds_pkg::REG_SLOT_LEN_0:    slot_len_r[0] <= pwdata[15:0];
        pds_pkg::REG_SLOT_LEN_1:    slot_len_r[1] <= pwdata[15:0];
        pds_pkg::REG_SLOT_LEN_2:    slot_len_r[2] <= pwdata[15:0];
        pds_pkg::REG_SLOT_LEN_3:    slot_len_r[3] <= pwdata[15:0];
        pds_pkg::REG_LINE_WIDTH:    line_w_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      pds_pkg::REG_PATTERN_COUNT: prdata = {29'd0, pat_cnt_r};
      pds_pkg::REG_SLOT_LEN_0:    prdata = {16'd0, slot_len_r[0]};
      pds_pkg::REG_SLOT_LEN_1:    prdata = {16'd0, slot_len_r[1]};
      pds_pkg::REG_SLOT_LEN_2:    prdata = {16'd0, slot_len_r[2]};
      pds_pkg::REG_SLOT_LEN_3:    prdata = {16'd0, slot_len_r[3]};
      pds_pkg::REG_LINE_WIDTH:    prdata = {16'd0, line_w_r};
      default:                    prdata = '0;
    endcase
  end

  // derived walk values
  logic [2:0]   eff_cnt, nx_slot;
  logic [L-1:0] step, t_sel;
  logic         pen, in_acc, out_free, vt_over, n_full;
  logic [VT_W:0] vt_plus;
  logic [L:0]    t_end;

  assign eff_cnt  = (pat_cnt_r > SLOT_CAP) ? SLOT_CAP : pat_cnt_r;
  assign nx_slot  = ({1'b0, slot_r} + 3'd1 >= eff_cnt) ? 3'd0 : {1'b0, slot_r} + 3'd1;
  assign step     = (rem_r < segrem_r) ? rem_r : segrem_r;
  assign pen      = ~slot_r[0];
  assign in_acc   = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign vt_plus  = {1'b0, vt_r} + (VT_W+1)'(pds_pkg::VERTS_PER_DASH);
  assign vt_over  = vt_plus > (VT_W+1)'(VERTEX_LIMIT);
  assign n_full   = dash_n_r >= DN_W'(MAX_DASHES_PER_POINT);
  assign t_end    = {1'b0, trav_r} + {1'b0, step};
  assign t_sel    = ip_idx_r[1] ? t_end[L-1:0] : trav_r;

  // shared root / divide unit
  pds_pkg::unit_req_t unit_req;
  logic [SW-1:0]      unit_operand;
  logic               unit_done;
  logic [L-1:0]       unit_res;

  pds_rootdiv u_rootdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (unit_req),
    .operand (unit_operand),
    .divisor (len_r),
    .done    (unit_done),
    .result  (unit_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pds_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.first || !have_prev_r) state_nxt = pds_pkg::S_SLOT_MUL;
          else if (!halted_r && eff_cnt != 3'd0) state_nxt = pds_pkg::S_SQ_X;
        end
      end
      pds_pkg::S_SLOT_MUL:  state_nxt = pds_pkg::S_SLOT_LOAD;
      pds_pkg::S_SLOT_LOAD: state_nxt = in_walk_r ? pds_pkg::S_WALK : pds_pkg::S_IDLE;
      pds_pkg::S_SQ_X:      state_nxt = pds_pkg::S_SQ_Y;
      pds_pkg::S_SQ_Y:      state_nxt = pds_pkg::S_SQ_SUM;
      pds_pkg::S_SQ_SUM:    state_nxt = pds_pkg::S_ROOT;
      pds_pkg::S_ROOT:      state_nxt = pds_pkg::S_ROOT_WAIT;
      pds_pkg::S_ROOT_WAIT: begin
        if (unit_done) state_nxt = (unit_res == '0) ? pds_pkg::S_IDLE : pds_pkg::S_WALK;
      end
      pds_pkg::S_WALK: begin
        if (segrem_r == '0) state_nxt = pds_pkg::S_FINISH;
        else if (!pen) state_nxt = pds_pkg::S_ADVANCE;
        else if (vt_over || n_full) state_nxt = pds_pkg::S_FINISH;
        else state_nxt = pds_pkg::S_IP_MUL;
      end
      pds_pkg::S_IP_MUL: state_nxt = pds_pkg::S_IP_DIV;
      pds_pkg::S_IP_DIV: state_nxt = pds_pkg::S_IP_WAIT;
      pds_pkg::S_IP_WAIT: begin
        if (unit_done) state_nxt = (ip_idx_r == 2'd3) ? pds_pkg::S_PUSH : pds_pkg::S_IP_MUL;
      end
      pds_pkg::S_PUSH: begin
        if (!pend_valid_r || out_free) state_nxt = pds_pkg::S_ADVANCE;
      end
      pds_pkg::S_ADVANCE: begin
        state_nxt = (rem_r == step) ? pds_pkg::S_SLOT_MUL : pds_pkg::S_WALK;
      end
      pds_pkg::S_FINISH: begin
        if (!pend_valid_r || out_free) state_nxt = pds_pkg::S_IDLE;
      end
      default: state_nxt = pds_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, unit requests, output load
  logic [L-1:0] mul_a, mul_b;
  logic         out_load;
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    unit_req     = '{start: 1'b0, op: pds_pkg::OP_SQRT};
    unit_operand = mul_p_r;
    out_load     = 1'b0;
    unique case (state_r)
      pds_pkg::S_SLOT_MUL: begin
        mul_a = L'(slot_len_r[slot_r]);
        mul_b = L'(line_w_r);
      end
      pds_pkg::S_SQ_X: begin
        mul_a = dxm_r;
        mul_b = dxm_r;
      end
      pds_pkg::S_SQ_Y: begin
        mul_a = dym_r;
        mul_b = dym_r;
      end
      pds_pkg::S_ROOT: begin
        unit_req     = '{start: 1'b1, op: pds_pkg::OP_SQRT};
        unit_operand = sum_r;
      end
      pds_pkg::S_IP_MUL: begin
        mul_a = ip_idx_r[0] ? dym_r : dxm_r;
        mul_b = t_sel;
      end
      pds_pkg::S_IP_DIV: unit_req = '{start: 1'b1, op: pds_pkg::OP_DIV};
      pds_pkg::S_PUSH, pds_pkg::S_FINISH: out_load = pend_valid_r & out_free;
      default: ;
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // interpolated coordinate from the quotient
  logic signed [CW-1:0] ip_p0;
  logic                 ip_neg;
  logic [CW+1:0]        ip_sum;
  assign ip_p0  = ip_idx_r[0] ? y0_r : x0_r;
  assign ip_neg = ip_idx_r[0] ? dyn_r : dxn_r;
  assign ip_sum = ip_neg ? {{2{ip_p0[CW-1]}}, ip_p0} - {1'b0, unit_res}
                         : {{2{ip_p0[CW-1]}}, ip_p0} + {1'b0, unit_res};

  // vertex differences at acceptance
  logic [L-1:0] dx, dy;
  logic [23:0]  slot_prod;
  assign dx = {in_ch.px[CW-1], in_ch.px} - {prev_x_r[CW-1], prev_x_r};
  assign dy = {in_ch.py[CW-1], in_ch.py} - {prev_y_r[CW-1], prev_y_r};
  assign slot_prod = mul_p_r[31:8];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pds_pkg::S_IDLE;
      have_prev_r  <= 1'b0;
      halted_r     <= 1'b0;
      in_walk_r    <= 1'b0;
      slot_r       <= '0;
      rem_r        <= '0;
      vt_r         <= '0;
      dash_n_r     <= '0;
      ip_idx_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      dropped_r    <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        pds_pkg::S_IDLE: begin
          if (in_acc) begin
            prev_x_r <= in_ch.px;
            prev_y_r <= in_ch.py;
            if (in_ch.first || !have_prev_r) begin
              have_prev_r <= 1'b1;
              slot_r      <= '0;
              vt_r        <= '0;
              halted_r    <= 1'b0;
              in_walk_r   <= 1'b0;
            end
          end
        end
        pds_pkg::S_SLOT_LOAD: rem_r <= (slot_prod == '0) ? L'(1) : L'(slot_prod);
        pds_pkg::S_ROOT_WAIT: begin
          if (unit_done) begin
            in_walk_r <= 1'b1;
            dash_n_r  <= '0;
            dropped_r <= 1'b0;
            if (rem_r == '0) rem_r <= L'(1);
          end
        end
        pds_pkg::S_WALK: begin
          if (segrem_r != '0 && pen) begin
            if (vt_over) begin
              halted_r  <= 1'b1;
              dropped_r <= 1'b1;
            end else if (n_full) begin
              dropped_r <= 1'b1;
            end
          end
          ip_idx_r <= '0;
        end
        pds_pkg::S_IP_WAIT: if (unit_done) ip_idx_r <= ip_idx_r + 2'd1;
        pds_pkg::S_PUSH: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b1;
            dash_n_r     <= dash_n_r + DN_W'(1);
            vt_r         <= vt_plus[VT_W-1:0];
          end
        end
        pds_pkg::S_ADVANCE: begin
          rem_r <= rem_r - step;
          if (rem_r == step) slot_r <= nx_slot[1:0];
        end
        pds_pkg::S_FINISH: if (!pend_valid_r || out_free) pend_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      pds_pkg::S_IDLE: begin
        x0_r  <= prev_x_r;
        y0_r  <= prev_y_r;
        dxn_r <= dx[L-1];
        dyn_r <= dy[L-1];
        dxm_r <= dx[L-1] ? -dx : dx;
        dym_r <= dy[L-1] ? -dy : dy;
      end
      pds_pkg::S_SQ_Y:   sum_r <= mul_p_r;
      pds_pkg::S_SQ_SUM: sum_r <= sum_r + mul_p_r;
      pds_pkg::S_ROOT_WAIT: begin
        len_r    <= unit_res;
        segrem_r <= unit_res;
        trav_r   <= '0;
      end
      pds_pkg::S_IP_WAIT: if (unit_done) dash_r[ip_idx_r] <= ip_sum[CW-1:0];
      pds_pkg::S_PUSH: begin
        if (!pend_valid_r || out_free) begin
          for (int i = 0; i < 4; i++) pend_r[i] <= dash_r[i];
        end
      end
      pds_pkg::S_ADVANCE: begin
        trav_r   <= t_end[L-1:0];
        segrem_r <= segrem_r - step;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 4; i++) out_pt_r[i] <= pend_r[i];
      out_last_r <= (state_r == pds_pkg::S_FINISH);
      out_drop_r <= (state_r == pds_pkg::S_FINISH) & dropped_r;
    end
  end

  assign in_ch.ready    = (state_r == pds_pkg::S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.start_x = out_pt_r[0];
  assign out_ch.start_y = out_pt_r[1];
  assign out_ch.end_x   = out_pt_r[2];
  assign out_ch.end_y   = out_pt_r[3];
  assign out_ch.last    = out_last_r;
  assign out_ch.dropped = out_drop_r;

  // checks on the walk
  a_vt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vt_r <= VT_W'(VERTEX_LIMIT)) else $error("vertex total past limit");
  a_dash_cap: assert property (@(posedge clk) disable iff (!rst_n)
    dash_n_r <= DN_W'(MAX_DASHES_PER_POINT)) else $error("dash count past cap");
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pds_pkg::S_WALK |-> rem_r != '0) else $error("empty slot in walk");
  a_seg_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pds_pkg::S_WALK |-> ({1'b0, trav_r} + {1'b0, segrem_r}) == {1'b0, len_r})
    else $error("walk position lost");
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pds_pkg::S_IDLE |-> !pend_valid_r) else $error("dash left pending");

endmodule
